### hdl/ptc_pkg.sv
// Shared types and codes for the pretrigger capture FIFO.
package ptc_pkg;

  localparam int WORD_W  = 64;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 3;
  localparam int MOVED_W = 9;
  localparam int LEVEL_W = 6;
  localparam int DEPTH_W = 9;

  localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DRAIN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FAULT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RECOVER = 3'd5;

  localparam logic [STAT_W-1:0] ST_PRE_STORED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED      = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FAULT_REJ   = 3'd3;
  localparam logic [STAT_W-1:0] ST_DRAINED     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTHING     = 3'd5;
  localparam logic [STAT_W-1:0] ST_OPENED      = 3'd6;
  localparam logic [STAT_W-1:0] ST_NO_EFFECT   = 3'd7;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_OPEN,
    OP_CLOSE,
    OP_DRAIN,
    OP_FAULT,
    OP_RECOVER,
    OP_NONE
  } ptc_op_t;

  typedef struct packed {
    ptc_op_t             op;
    logic [WORD_W-1:0]   word;
  } ptc_cmd_t;

endpackage

### hdl/ptc_ifs.sv
// Channel interfaces of the pretrigger capture FIFO.
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] frame_word;
  modport source (output valid, output kind, output frame_word, input ready);
  modport sink   (input valid, input kind, input frame_word, output ready);
endinterface

interface ptc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic        out_valid;
  logic [2:0]  status;
  logic [8:0]  moved_count;
  logic [5:0]  fifo_level;
  modport source (output valid, output out_word, output out_valid, output status,
                  output moved_count, output fifo_level, input ready);
  modport sink   (input valid, input out_word, input out_valid, input status,
                  input moved_count, input fifo_level, output ready);
endinterface

interface ptc_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/ptc_front.sv
// Front end: accept items, decode the kind and hold them in a two-entry queue.
module ptc_front
  import ptc_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  ptc_in_if.sink   in_chan,
  output logic     cmd_valid,
  output ptc_cmd_t cmd,
  input  logic     cmd_pop
);

  ptc_cmd_t   q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  ptc_cmd_t   dec;

  always_comb begin
    unique case (in_chan.kind)
      KIND_PUSH:    dec.op = OP_PUSH;
      KIND_OPEN:    dec.op = OP_OPEN;
      KIND_CLOSE:   dec.op = OP_CLOSE;
      KIND_DRAIN:   dec.op = OP_DRAIN;
      KIND_FAULT:   dec.op = OP_FAULT;
      KIND_RECOVER: dec.op = OP_RECOVER;
      default:      dec.op = OP_NONE;
    endcase
    dec.word = WORD_W'(in_chan.frame_word[WORD_BITS-1:0]);
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = (cnt_r != 2'd0);
  assign cmd           = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

### hdl/ptc_back.sv
// Back end: pre-trigger ring, FIFO, session control and the result register.
module ptc_back
  import ptc_pkg::*;
#(
  parameter int PRE_MAX    = 256,
  parameter int FIFO_DEPTH = 64,
  parameter int WORD_BITS  = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  ptc_cmd_t   cmd,
  output logic       cmd_pop,
  ptc_out_if.source  out_chan,
  ptc_cfg_if.sink    cfg_chan
);

  localparam int PW = (PRE_MAX > 1) ? $clog2(PRE_MAX) : 1;
  localparam int CW = $clog2(PRE_MAX + 1);
  localparam int FW = $clog2(FIFO_DEPTH);
  localparam int RESET_DEPTH = (PRE_MAX < 256) ? PRE_MAX : 256;

  typedef enum logic [1:0] {S_IDLE, S_COPY_RD, S_COPY_WR, S_DRAIN} state_t;

  function automatic logic [FW-1:0] fifo_inc(input logic [FW-1:0] p);
    return (p == FW'(FIFO_DEPTH - 1)) ? '0 : p + FW'(1);
  endfunction

  function automatic logic [FW-1:0] fifo_lvl(input logic [FW-1:0] h, input logic [FW-1:0] t);
    logic [FW:0] s;
    s = {1'b0, h} + (FW+1)'(FIFO_DEPTH) - {1'b0, t};
    return (h >= t) ? (h - t) : s[FW-1:0];
  endfunction

  function automatic logic [PW-1:0] pre_inc(input logic [PW-1:0] p, input logic [CW-1:0] d);
    logic [CW-1:0] pn;
    pn = CW'(p) + CW'(1);
    return (pn == d) ? '0 : pn[PW-1:0];
  endfunction

  logic [WORD_BITS-1:0] pre_mem  [PRE_MAX];
  logic [WORD_BITS-1:0] fifo_mem [FIFO_DEPTH];
  logic [WORD_BITS-1:0] pre_rdata, fifo_rdata;

  state_t            state_r, state_nxt;
  logic              session_r, session_nxt;
  logic              fault_r, fault_nxt;
  logic [PW-1:0]     pre_head_r, pre_head_nxt;
  logic [CW-1:0]     pre_count_r, pre_count_nxt;
  logic [CW-1:0]     depth_r, depth_nxt;
  logic [FW-1:0]     fhead_r, fhead_nxt;
  logic [FW-1:0]     ftail_r, ftail_nxt;
  logic [PW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     moved_r, moved_nxt;

  logic              res_vld_r, res_vld_nxt;
  logic [WORD_W-1:0] res_word_r, res_word_nxt;
  logic              res_ovalid_r, res_ovalid_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [MOVED_W-1:0] res_moved_r, res_moved_nxt;
  logic [LEVEL_W-1:0] res_level_r, res_level_nxt;

  logic                 load, ld_ovalid;
  logic [STAT_W-1:0]    ld_status;
  logic [CW-1:0]        ld_moved;
  logic [WORD_BITS-1:0] ld_word;
  logic                 pre_we, fifo_we;
  logic [WORD_BITS-1:0] fifo_wdata;
  logic                 out_free, fifo_full;
  logic [31:0]          cfg_val, moved32, level32;

  assign cfg_chan.ready = 1'b1;
  assign out_free  = !res_vld_r || out_chan.ready;
  assign fifo_full = (fifo_inc(fhead_r) == ftail_r);
  assign cfg_val   = 32'(cfg_chan.data);

  always_comb begin
    state_nxt     = state_r;
    session_nxt   = session_r;
    fault_nxt     = fault_r;
    pre_head_nxt  = pre_head_r;
    pre_count_nxt = pre_count_r;
    depth_nxt     = depth_r;
    fhead_nxt     = fhead_r;
    ftail_nxt     = ftail_r;
    rd_nxt        = rd_r;
    moved_nxt     = moved_r;
    cmd_pop       = 1'b0;
    pre_we        = 1'b0;
    fifo_we       = 1'b0;
    fifo_wdata    = cmd.word[WORD_BITS-1:0];
    load          = 1'b0;
    ld_ovalid     = 1'b0;
    ld_status     = ST_NO_EFFECT;
    ld_moved      = '0;
    ld_word       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_PUSH: begin
              load = 1'b1;
              if (fault_r) begin
                ld_status = ST_FAULT_REJ;
              end else if (!session_r) begin
                pre_we       = 1'b1;
                pre_head_nxt = pre_inc(pre_head_r, depth_r);
                if (pre_count_r < depth_r) begin
                  pre_count_nxt = pre_count_r + CW'(1);
                end
                ld_status = ST_PRE_STORED;
              end else if (!fifo_full) begin
                fifo_we   = 1'b1;
                fhead_nxt = fifo_inc(fhead_r);
                ld_status = ST_QUEUED;
              end else begin
                ld_status = ST_DROPPED;
              end
            end
            OP_OPEN: begin
              if (session_r) begin
                load = 1'b1;
              end else begin
                session_nxt = 1'b1;
                if (pre_count_r == '0) begin
                  load         = 1'b1;
                  ld_status    = ST_OPENED;
                  pre_head_nxt = '0;
                end else begin
                  // Oldest entry sits at the head once the ring has wrapped.
                  rd_nxt    = (pre_count_r >= depth_r) ? pre_head_r : '0;
                  moved_nxt = '0;
                  state_nxt = S_COPY_RD;
                end
              end
            end
            OP_CLOSE: begin
              load        = 1'b1;
              session_nxt = 1'b0;
            end
            OP_DRAIN: begin
              if (session_r && !fault_r && (fhead_r != ftail_r)) begin
                state_nxt = S_DRAIN;
              end else begin
                load      = 1'b1;
                ld_status = ST_NOTHING;
              end
            end
            OP_FAULT: begin
              load      = 1'b1;
              fault_nxt = 1'b1;
            end
            OP_RECOVER: begin
              load      = 1'b1;
              fault_nxt = 1'b0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_COPY_RD: begin
        if (fifo_full) begin
          load          = 1'b1;
          ld_status     = ST_OPENED;
          ld_moved      = moved_r;
          pre_count_nxt = '0;
          pre_head_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        fifo_we    = 1'b1;
        fifo_wdata = pre_rdata;
        fhead_nxt  = fifo_inc(fhead_r);
        rd_nxt     = pre_inc(rd_r, depth_r);
        moved_nxt  = moved_r + CW'(1);
        if (moved_nxt == pre_count_r) begin
          load          = 1'b1;
          ld_status     = ST_OPENED;
          ld_moved      = moved_nxt;
          pre_count_nxt = '0;
          pre_head_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_DRAIN: begin
        load      = 1'b1;
        ld_status = ST_DRAINED;
        ld_ovalid = 1'b1;
        ld_word   = fifo_rdata;
        ftail_nxt = fifo_inc(ftail_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_chan.valid) begin
      pre_head_nxt  = '0;
      pre_count_nxt = '0;
      if (cfg_val == 32'd0) begin
        depth_nxt = CW'(1);
      end else if (cfg_val > 32'(PRE_MAX)) begin
        depth_nxt = CW'(PRE_MAX);
      end else begin
        depth_nxt = cfg_val[CW-1:0];
      end
    end
  end

  assign moved32 = 32'(ld_moved);
  assign level32 = 32'(fifo_lvl(fhead_nxt, ftail_nxt));

  always_comb begin
    res_vld_nxt    = res_vld_r && !out_chan.ready;
    res_word_nxt   = res_word_r;
    res_ovalid_nxt = res_ovalid_r;
    res_status_nxt = res_status_r;
    res_moved_nxt  = res_moved_r;
    res_level_nxt  = res_level_r;
    if (load) begin
      res_vld_nxt    = 1'b1;
      res_word_nxt   = WORD_W'(ld_word);
      res_ovalid_nxt = ld_ovalid;
      res_status_nxt = ld_status;
      res_moved_nxt  = moved32[MOVED_W-1:0];
      res_level_nxt  = level32[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      session_r   <= 1'b0;
      fault_r     <= 1'b0;
      pre_head_r  <= '0;
      pre_count_r <= '0;
      depth_r     <= CW'(RESET_DEPTH);
      fhead_r     <= '0;
      ftail_r     <= '0;
      res_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      session_r   <= session_nxt;
      fault_r     <= fault_nxt;
      pre_head_r  <= pre_head_nxt;
      pre_count_r <= pre_count_nxt;
      depth_r     <= depth_nxt;
      fhead_r     <= fhead_nxt;
      ftail_r     <= ftail_nxt;
      res_vld_r   <= res_vld_nxt;
    end
    rd_r         <= rd_nxt;
    moved_r      <= moved_nxt;
    res_word_r   <= res_word_nxt;
    res_ovalid_r <= res_ovalid_nxt;
    res_status_r <= res_status_nxt;
    res_moved_r  <= res_moved_nxt;
    res_level_r  <= res_level_nxt;
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[pre_head_r] <= cmd.word[WORD_BITS-1:0];
    end
    pre_rdata <= pre_mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fhead_r] <= fifo_wdata;
    end
    fifo_rdata <= fifo_mem[ftail_r];
  end

  assign out_chan.valid       = res_vld_r;
  assign out_chan.out_word    = res_word_r;
  assign out_chan.out_valid   = res_ovalid_r;
  assign out_chan.status      = res_status_r;
  assign out_chan.moved_count = res_moved_r;
  assign out_chan.fifo_level  = res_level_r;

endmodule

### hdl/pretrigger_capture_fifo.sv
// Top level of the pretrigger capture FIFO: front queue, back end and checks.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    kind[2:0], frame_word[63:0]
//   out_chan  out  valid/ready    out_word, out_valid, status, moved_count, fifo_level
//   cfg_chan  in   valid/ready    data[8:0] (pre_depth), ready tied high
//
// Push, close, fault, recover and refused commands finish in the idle state; a drain
// passes through a drain state because of the registered FIFO read. An open copies
// each pre-stored entry through a read state and then a write state of the copy loop,
// and stops early in the read state when the FIFO is full.
// Reset is synchronous, active low; neither store is cleared, so no clearing pass.
// A two-entry queue keeps taking items, while it has room, as the back end works or
// its result waits on out_chan.ready.
module pretrigger_capture_fifo
  import ptc_pkg::*;
#(
  parameter int PRE_MAX    = 256,
  parameter int FIFO_DEPTH = 64,
  parameter int WORD_BITS  = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ptc_in_if.sink     in_chan,
  ptc_out_if.source  out_chan,
  ptc_cfg_if.sink    cfg_chan
);

  logic     cmd_valid;
  ptc_cmd_t cmd;
  logic     cmd_pop;

  // Decode and buffer incoming items.
  ptc_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Execute commands against the stores and hold the result.
  ptc_back #(
    .PRE_MAX    (PRE_MAX),
    .FIFO_DEPTH (FIFO_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_chan  (out_chan),
    .cfg_chan  (cfg_chan)
  );

  // A drained word only comes with the drained status.
  a_drain_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_valid) |-> (out_chan.status == ST_DRAINED))
    else $error("drained word without drained status");

  // Moved entries are reported on an open only.
  a_moved_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != ST_OPENED)) |-> (out_chan.moved_count == '0))
    else $error("moved count on a step other than open");

  // No drained word means a zero word.
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.out_valid) |-> (out_chan.out_word == '0))
    else $error("nonzero word without drain");

endmodule
